### hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hdl/psps_pkg.sv
package psps_pkg;

    localparam int RAW_W     = 32;
    localparam int CFG_TIME_W = 24;
    localparam int OUT_VAL_W = 16;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // reciprocal of ten, exact for every 32-bit count after a shift of 35
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    typedef enum logic [1:0] {
        PH_RESET = 2'd0,
        PH_WAIT  = 2'd1,
        PH_WRITE = 2'd2,
        PH_READ  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_INIT      = 2'd1,
        ACT_PTR_WRITE = 2'd2,
        ACT_READ      = 2'd3
    } t_action;

    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_WRITE_DONE = 2'd1;
    localparam logic [1:0] CMD_READ_DONE  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_POLL_INTERVAL    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_WAIT      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESPONSE_TIMEOUT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RAW_LIMIT       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEVICE_ADDRESS  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REGISTER_ADDRESS = 3'd5;

    localparam logic [CFG_TIME_W-1:0] RST_POLL_INTERVAL    = 24'd8000000;
    localparam logic [CFG_TIME_W-1:0] RST_WRITE_WAIT       = 24'd500;
    localparam logic [CFG_TIME_W-1:0] RST_RESPONSE_TIMEOUT = 24'd10000000;
    localparam logic [RAW_W-1:0]      RST_RAW_LIMIT        = 32'h000F_FFFF;
    localparam logic [6:0]            RST_DEVICE_ADDRESS   = 7'h33;
    localparam logic [7:0]            RST_REGISTER_ADDRESS = 8'h00;

    typedef struct packed {
        logic [1:0]       command;
        logic [RAW_W-1:0] raw_pm1;
        logic [RAW_W-1:0] raw_pm25;
        logic [RAW_W-1:0] raw_pm10;
    } t_in_item;

    typedef struct packed {
        t_action              bus_action;
        logic [6:0]           bus_address;
        logic [7:0]           pointer_byte;
        logic [OUT_VAL_W-1:0] pm1_value;
        logic [OUT_VAL_W-1:0] pm25_value;
        logic [OUT_VAL_W-1:0] pm10_value;
        logic                 read_error;
        logic                 values_updated;
    } t_out_item;

    typedef struct packed {
        logic [CFG_TIME_W-1:0] poll_interval_us;
        logic [CFG_TIME_W-1:0] write_wait_us;
        logic [CFG_TIME_W-1:0] response_timeout_us;
        logic [RAW_W-1:0]      raw_limit;
        logic [6:0]            device_address;
        logic [7:0]            register_address;
    } t_cfg;

endpackage

### hdl/particle_sensor_poll_sequencer.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------
// in       | input     | i_in_valid / o_in_ready | i_in_data  (t_in_item)
// out      | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
// cfg      | input     | i_cfg_we (no wait)     | i_cfg_index, i_cfg_data
//
// every transfer in yields one transfer out, passing through the input register and then the result register
// one item per cycle sustained while out is ready: input register, one step of phase logic, result register
// the divide by ten is a constant reciprocal multiply in the step, one per count
// reset (synchronous, active low) clears the phase, timers and stores and loads the config defaults
// a stalled output holds; the input register keeps taking items while the result
// register drains, so ready drops only when both are full and out is stalled

`include "assert_macros.svh"

module particle_sensor_poll_sequencer #(
    parameter int TIMER_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  psps_pkg::t_in_item                  i_in_data,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output psps_pkg::t_out_item                 o_out_data,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [psps_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [psps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // config register file
    psps_pkg::t_cfg      r_cfg;

    // input register
    logic                r_in_valid;
    psps_pkg::t_in_item  r_in;

    // result register
    logic                r_out_valid;
    psps_pkg::t_out_item r_out;

    psps_pkg::t_out_item step_result;
    logic                advance;
    logic                in_xfer;

    // item moves from input register into the result register
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    psps_core #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_result(step_result)
    );

    // config writes, unlisted indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval_us    <= psps_pkg::RST_POLL_INTERVAL;
            r_cfg.write_wait_us       <= psps_pkg::RST_WRITE_WAIT;
            r_cfg.response_timeout_us <= psps_pkg::RST_RESPONSE_TIMEOUT;
            r_cfg.raw_limit           <= psps_pkg::RST_RAW_LIMIT;
            r_cfg.device_address      <= psps_pkg::RST_DEVICE_ADDRESS;
            r_cfg.register_address    <= psps_pkg::RST_REGISTER_ADDRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psps_pkg::REG_POLL_INTERVAL: begin
                    r_cfg.poll_interval_us <= i_cfg_data[psps_pkg::CFG_TIME_W-1:0];
                end
                psps_pkg::REG_WRITE_WAIT: begin
                    r_cfg.write_wait_us <= i_cfg_data[psps_pkg::CFG_TIME_W-1:0];
                end
                psps_pkg::REG_RESPONSE_TIMEOUT: begin
                    r_cfg.response_timeout_us <= i_cfg_data[psps_pkg::CFG_TIME_W-1:0];
                end
                psps_pkg::REG_RAW_LIMIT: begin
                    r_cfg.raw_limit <= i_cfg_data[psps_pkg::RAW_W-1:0];
                end
                psps_pkg::REG_DEVICE_ADDRESS: begin
                    r_cfg.device_address <= i_cfg_data[6:0];
                end
                psps_pkg::REG_REGISTER_ADDRESS: begin
                    r_cfg.register_address <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    `ASSERT_CLK(a_empty_out_takes_input,
        !r_out_valid |-> o_in_ready,
        "input stalled with an empty result register")
    `ASSERT_CLK(a_held_item_stable,
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)),
        "held input item changed or was dropped")
    `ASSERT_CLK(a_step_fills_out,
        advance |=> r_out_valid,
        "step did not load the result register")

endmodule

### hdl/psps_scale.sv
module psps_scale #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic [psps_pkg::RAW_W-1:0] i_raw,
    output logic [VALUE_WIDTH-1:0]     o_value
);

    localparam int PROD_W = 2 * psps_pkg::RAW_W;
    localparam int QUOT_W = PROD_W - psps_pkg::RECIP10_SHIFT;
    localparam logic [32:0] VALUE_MAX = (33'd1 << VALUE_WIDTH) - 33'd1;

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;

    // raw / 10 by reciprocal multiply
    assign prod = PROD_W'(i_raw) * PROD_W'(psps_pkg::RECIP10);
    assign quot = prod[PROD_W-1:psps_pkg::RECIP10_SHIFT];

    always_comb begin
        if (33'(quot) > VALUE_MAX) begin
            o_value = VALUE_MAX[VALUE_WIDTH-1:0];
        end else begin
            o_value = VALUE_WIDTH'(quot);
        end
    end

endmodule

### hdl/psps_core.sv
`include "assert_macros.svh"

module psps_core #(
    parameter int TIMER_WIDTH = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  psps_pkg::t_in_item  i_item,
    input  psps_pkg::t_cfg      i_cfg,
    output psps_pkg::t_out_item o_result
);

    localparam int VALUE_WIDTH = psps_pkg::OUT_VAL_W;
    localparam int CMP_W = (TIMER_WIDTH > psps_pkg::CFG_TIME_W) ?
                           TIMER_WIDTH : psps_pkg::CFG_TIME_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    psps_pkg::t_phase       r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_since_start, n_since_start;
    logic [TIMER_WIDTH-1:0] r_since_resp, n_since_resp;
    logic [VALUE_WIDTH-1:0] r_pm1, n_pm1;
    logic [VALUE_WIDTH-1:0] r_pm25, n_pm25;
    logic [VALUE_WIDTH-1:0] r_pm10, n_pm10;
    logic                   r_error, n_error;

    logic [TIMER_WIDTH-1:0] tick_start, tick_resp;
    logic [VALUE_WIDTH-1:0] sc_pm1, sc_pm25, sc_pm10;
    logic                   over_limit;
    psps_pkg::t_action      action;
    logic                   updated;

    psps_scale #(.VALUE_WIDTH(VALUE_WIDTH)) u_scale_pm1 (
        .i_raw(i_item.raw_pm1), .o_value(sc_pm1)
    );
    psps_scale #(.VALUE_WIDTH(VALUE_WIDTH)) u_scale_pm25 (
        .i_raw(i_item.raw_pm25), .o_value(sc_pm25)
    );
    psps_scale #(.VALUE_WIDTH(VALUE_WIDTH)) u_scale_pm10 (
        .i_raw(i_item.raw_pm10), .o_value(sc_pm10)
    );

    assign over_limit = (i_item.raw_pm1 > i_cfg.raw_limit) ||
                        (i_item.raw_pm25 > i_cfg.raw_limit) ||
                        (i_item.raw_pm10 > i_cfg.raw_limit);

    // saturating microsecond timers
    always_comb begin
        tick_start = r_since_start;
        tick_resp  = r_since_resp;
        if (i_item.command == psps_pkg::CMD_TICK) begin
            if (r_since_start != TIMER_MAX) begin
                tick_start = r_since_start + 1'b1;
            end
            if (r_since_resp != TIMER_MAX) begin
                tick_resp = r_since_resp + 1'b1;
            end
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_since_start = tick_start;
        n_since_resp  = tick_resp;
        n_pm1         = r_pm1;
        n_pm25        = r_pm25;
        n_pm10        = r_pm10;
        n_error       = r_error;
        action        = psps_pkg::ACT_NONE;
        updated       = 1'b0;
        unique case (r_phase)
            psps_pkg::PH_RESET: begin
                action        = psps_pkg::ACT_INIT;
                n_since_start = '0;
                n_since_resp  = '0;
                n_phase       = psps_pkg::PH_WAIT;
            end
            psps_pkg::PH_WAIT: begin
                if (CMP_W'(tick_start) > CMP_W'(i_cfg.poll_interval_us)) begin
                    n_since_start = '0;
                    n_since_resp  = '0;
                    action        = psps_pkg::ACT_PTR_WRITE;
                    n_phase       = psps_pkg::PH_WRITE;
                end
            end
            psps_pkg::PH_WRITE: begin
                if (i_item.command == psps_pkg::CMD_WRITE_DONE ||
                    CMP_W'(tick_start) > CMP_W'(i_cfg.write_wait_us)) begin
                    action  = psps_pkg::ACT_READ;
                    n_phase = psps_pkg::PH_READ;
                end
            end
            psps_pkg::PH_READ: begin
                if (i_item.command == psps_pkg::CMD_READ_DONE) begin
                    n_since_start = '0;
                    n_since_resp  = '0;
                    if (over_limit) begin
                        n_error = 1'b1;
                        n_phase = psps_pkg::PH_RESET;
                    end else begin
                        n_error = 1'b0;
                        n_pm1   = sc_pm1;
                        n_pm25  = sc_pm25;
                        n_pm10  = sc_pm10;
                        updated = 1'b1;
                        n_phase = psps_pkg::PH_WAIT;
                    end
                end
            end
            default: begin
                n_phase = psps_pkg::PH_RESET;
            end
        endcase
        // response timeout overrides the phase, the action still goes out
        if (CMP_W'(n_since_resp) > CMP_W'(i_cfg.response_timeout_us)) begin
            n_phase = psps_pkg::PH_RESET;
        end
    end

    always_comb begin
        o_result.bus_action     = action;
        o_result.bus_address    = (action != psps_pkg::ACT_NONE) ?
                                  i_cfg.device_address : 7'd0;
        o_result.pointer_byte   = (action == psps_pkg::ACT_PTR_WRITE) ?
                                  i_cfg.register_address : 8'd0;
        o_result.pm1_value      = psps_pkg::OUT_VAL_W'(n_pm1);
        o_result.pm25_value     = psps_pkg::OUT_VAL_W'(n_pm25);
        o_result.pm10_value     = psps_pkg::OUT_VAL_W'(n_pm10);
        o_result.read_error     = n_error;
        o_result.values_updated = updated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= psps_pkg::PH_RESET;
            r_since_start <= '0;
            r_since_resp  <= '0;
            r_pm1         <= '0;
            r_pm25        <= '0;
            r_pm10        <= '0;
            r_error       <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_since_start <= n_since_start;
            r_since_resp  <= n_since_resp;
            r_pm1         <= n_pm1;
            r_pm25        <= n_pm25;
            r_pm10        <= n_pm10;
            r_error       <= n_error;
        end
    end

    `ASSERT_CLK(a_reset_goes_wait,
        (i_step && r_phase == psps_pkg::PH_RESET) |=> (r_phase == psps_pkg::PH_WAIT),
        "init step did not move to waiting")
    `ASSERT_CLK(a_ptr_goes_write,
        (i_step && o_result.bus_action == psps_pkg::ACT_PTR_WRITE)
            |=> (r_phase == psps_pkg::PH_WRITE),
        "pointer write did not move to write pending")
    `ASSERT_CLK(a_idle_holds_state,
        !i_step |=> ($stable(r_phase) && $stable(r_since_start) && $stable(r_since_resp)),
        "sequencer state moved without a step")

endmodule
